// ===== rtl/twagg_pkg.sv =====
package twagg_pkg;

  localparam int TIME_W    = 32;
  localparam int TEMP_W    = 12;
  localparam int HUM_W     = 10;
  localparam int RAIN_W    = 15;
  localparam int WINDOW_W  = 16;
  localparam int RAIN_SUM_W = 21;

  localparam logic [WINDOW_W-1:0]   WINDOW_RESET = 16'd1440;
  localparam logic [RAIN_SUM_W-1:0] RAIN_LIMIT   = 21'd1280000;

  // Bit positions in the per-record presence mask.
  localparam int PRES_TEMP = 0;
  localparam int PRES_HUM  = 1;
  localparam int PRES_RAIN = 2;

  typedef logic        [TIME_W-1:0]     time_t;
  typedef logic signed [TEMP_W-1:0]     temp_t;
  typedef logic        [HUM_W-1:0]      hum_t;
  typedef logic        [RAIN_W-1:0]     rain_t;
  typedef logic        [WINDOW_W-1:0]   window_t;
  typedef logic        [RAIN_SUM_W-1:0] rain_sum_t;
  typedef logic        [2:0]            pres_t;

  typedef struct packed {
    time_t tm;
    temp_t temp;
    hum_t  hum;
    rain_t rain;
    pres_t pres;
  } entry_t;

endpackage

// ===== rtl/twagg_ifs.sv =====
interface twagg_rec_if import twagg_pkg::*; ();
  logic  valid;
  logic  ready;
  time_t time_minutes;
  temp_t temperature;
  logic  temperature_present;
  hum_t  humidity;
  logic  humidity_present;
  rain_t rainfall;
  logic  rainfall_present;

  modport source (output valid, time_minutes, temperature, temperature_present, humidity,
                  humidity_present, rainfall, rainfall_present, input ready);
  modport sink (input valid, time_minutes, temperature, temperature_present, humidity,
                humidity_present, rainfall, rainfall_present, output ready);
endinterface

interface twagg_res_if import twagg_pkg::*; ();
  logic      valid;
  logic      ready;
  logic      status;
  temp_t     low_temperature;
  temp_t     high_temperature;
  logic      temperature_known;
  hum_t      low_humidity;
  logic      humidity_known;
  rain_sum_t rainfall_total;
  logic      rainfall_known;

  modport source (output valid, status, low_temperature, high_temperature, temperature_known,
                  low_humidity, humidity_known, rainfall_total, rainfall_known, input ready);
  modport sink (input valid, status, low_temperature, high_temperature, temperature_known,
                low_humidity, humidity_known, rainfall_total, rainfall_known, output ready);
endinterface

interface twagg_cfg_if import twagg_pkg::*; ();
  logic    valid;
  logic    ready;
  window_t window_minutes;

  modport source (output valid, window_minutes, input ready);
  modport sink (input valid, window_minutes, output ready);
endinterface

// ===== rtl/trailing_day_weather_aggregate_unit.sv =====
// Flow: a rejected or first record goes straight to DONE on acceptance; any other record
// passes through PRIME and WALK, where the walk ends at the oldest filled entry or stops at
// a record outside the window, reading the older records inside the window one per cycle
// from the ring. Throughput: one record at a time; a finished result waits in DONE until
// the result register is free, and no new record is taken meanwhile.
// Reset (synchronous, rst high): ring empty, write slot 0, window 1440 minutes, no result held.
module trailing_day_weather_aggregate_unit import twagg_pkg::*; #(
  parameter int RING_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  twagg_rec_if.sink   record,
  twagg_res_if.source result,
  twagg_cfg_if.sink   cfg
);

  localparam int SLOT_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int COUNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
  localparam logic [COUNT_W-1:0] FULL      = COUNT_W'(RING_DEPTH);

  typedef enum logic [1:0] {IDLE, PRIME, WALK, DONE} state_t;

  state_t            state;
  entry_t            ring [RING_DEPTH];
  entry_t            rd_entry;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] addr;
  logic [COUNT_W-1:0] filled_count;
  logic [COUNT_W-1:0] filled_next;
  logic [COUNT_W-1:0] left;
  window_t           window;
  time_t             last_time;
  time_t             now;
  logic              reject;
  logic              rejected;
  temp_t             tmin, tmax;
  hum_t              hmin;
  rain_sum_t         rsum;
  logic              tk, hk, rk;
  logic              accept;
  logic              in_window;
  logic [RAIN_SUM_W:0] rain_add;

  function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
    return (s == '0) ? LAST_SLOT : s - 1'b1;
  endfunction

  assign record.ready = (state == IDLE);
  assign cfg.ready    = 1'b1;
  assign accept       = record.valid && record.ready;
  assign reject       = (filled_count != '0) && (record.time_minutes <= last_time);
  assign filled_next  = (filled_count < FULL) ? filled_count + 1'b1 : filled_count;
  assign in_window    = (now - rd_entry.tm) < {{(TIME_W-WINDOW_W){1'b0}}, window};
  assign rain_add     = {1'b0, rsum} + (RAIN_SUM_W+1)'(rd_entry.rain);

  // Record ring: written once per accepted, non-rejected record, read every cycle at the walk address.
  always_ff @(posedge clk) begin
    if (accept && !reject) begin
      ring[write_slot] <= '{tm: record.time_minutes, temp: record.temperature,
                            hum: record.humidity, rain: record.rainfall,
                            pres: {record.rainfall_present, record.humidity_present,
                                   record.temperature_present}};
    end
    rd_entry <= ring[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      write_slot   <= '0;
      filled_count <= '0;
      window       <= WINDOW_RESET;
      result.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        window <= cfg.window_minutes;
      end
      if (result.valid && result.ready && state != DONE) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            rejected <= reject;
            if (reject) begin
              tk    <= 1'b0;
              hk    <= 1'b0;
              rk    <= 1'b0;
              tmin  <= '0;
              tmax  <= '0;
              hmin  <= '0;
              rsum  <= '0;
              state <= DONE;
            end else begin
              // The new record always counts, whatever the window.
              now          <= record.time_minutes;
              last_time    <= record.time_minutes;
              tk           <= record.temperature_present;
              hk           <= record.humidity_present;
              rk           <= record.rainfall_present;
              tmin         <= record.temperature_present ? record.temperature : '0;
              tmax         <= record.temperature_present ? record.temperature : '0;
              hmin         <= record.humidity_present ? record.humidity : '0;
              rsum         <= record.rainfall_present ? RAIN_SUM_W'(record.rainfall) : '0;
              addr         <= prev_slot(write_slot);
              write_slot   <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
              filled_count <= filled_next;
              left         <= filled_next - 1'b1;
              state        <= (filled_count == '0) ? DONE : PRIME;
            end
          end
        end
        PRIME: begin
          addr  <= prev_slot(addr);
          state <= WALK;
        end
        WALK: begin
          addr <= prev_slot(addr);
          if (!in_window) begin
            state <= DONE;
          end else begin
            if (rd_entry.pres[PRES_TEMP]) begin
              if (!tk || rd_entry.temp < tmin) tmin <= rd_entry.temp;
              if (!tk || rd_entry.temp > tmax) tmax <= rd_entry.temp;
              tk <= 1'b1;
            end
            if (rd_entry.pres[PRES_HUM]) begin
              if (!hk || rd_entry.hum < hmin) hmin <= rd_entry.hum;
              hk <= 1'b1;
            end
            if (rd_entry.pres[PRES_RAIN]) begin
              rsum <= (rain_add > {1'b0, RAIN_LIMIT}) ? RAIN_LIMIT : rain_add[RAIN_SUM_W-1:0];
              rk   <= 1'b1;
            end
            left <= left - 1'b1;
            if (left == COUNT_W'(1)) begin
              state <= DONE;
            end
          end
        end
        DONE: begin
          // Hold here until the result register is free.
          if (!result.valid || result.ready) begin
            result.valid             <= 1'b1;
            result.status            <= rejected;
            result.low_temperature   <= tmin;
            result.high_temperature  <= tmax;
            result.temperature_known <= tk;
            result.low_humidity      <= hmin;
            result.humidity_known    <= hk;
            result.rainfall_total    <= rsum;
            result.rainfall_known    <= rk;
            state                    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !record.ready)
    else $error("record taken while a walk is in progress");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled_count <= FULL)
    else $error("fill count beyond ring depth");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status) |->
      (!result.temperature_known && !result.humidity_known && !result.rainfall_known &&
       result.rainfall_total == '0 && result.low_humidity == '0))
    else $error("rejected record carries aggregates");

  a_reject_keeps_ring: assert property (@(posedge clk) disable iff (rst)
    (accept && reject) |=> ($stable(write_slot) && $stable(filled_count)))
    else $error("rejected record changed the ring");

  a_rain_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.rainfall_total <= RAIN_LIMIT))
    else $error("rainfall sum above its limit");

endmodule
